// ===== rtl/wbss_pkg.sv =====
`timescale 1ns / 1ps
// Package for the wildcard byte signature scanner.
// Holds the shared constants, register index codes and the config and match structs.
package wbss_pkg;

   localparam int PATTERN_MAX_DEF  = 16;
   localparam int WINDOW_BYTES_DEF = 32;
   localparam int PATTERN_BYTES    = 16;
   localparam int CALL_BYTES       = 5;
   localparam int CSR_INDEX_W      = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW   = 4'd0,
      CSR_PATTERN_HIGH  = 4'd1,
      CSR_WILD_MASK     = 4'd2,
      CSR_PATTERN_LEN   = 4'd3,
      CSR_TARGET_OFFSET = 4'd4,
      CSR_CALL_MODE     = 4'd5,
      CSR_FIND_ALL      = 4'd6,
      CSR_MAX_MATCHES   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] wild_mask;
      logic [4:0]  pattern_len;
      logic [4:0]  target_offset;
      logic        call_mode;
      logic        find_all;
      logic [15:0] max_matches;
   } cfg_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] rel;
   } match_type;

endpackage

// ===== rtl/wbss_match.sv =====
`timescale 1ns / 1ps
// Masked pattern compare over the byte window and rel32 field extraction.
// Depends on wbss_pkg for the config and match structs.
module wbss_match
   import wbss_pkg::*;
#(
   parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
   input  logic [WINDOW_BYTES-1:0][7:0]      window,
   input  logic [$clog2(WINDOW_BYTES+1)-1:0] fill,
   input  logic [$clog2(WINDOW_BYTES+1)-1:0] span,
   input  logic [4:0]                        len,
   input  logic [5:0]                        off,
   input  cfg_type                           cfg,
   input  logic                              stopped,
   output match_type                         result
);

   localparam int SW      = $clog2(WINDOW_BYTES + 1);
   localparam int IW      = $clog2(WINDOW_BYTES);
   localparam int LEN_USE = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;

   logic [8*PATTERN_BYTES-1:0] pattern;
   logic [SW-1:0]              a0;
   logic [IW-1:0]              rel_idx [4];

   assign pattern = {cfg.pattern_high, cfg.pattern_low};
   assign a0      = span - SW'(2) - SW'(off);

   always_comb begin
      logic [IW-1:0] idx;
      logic          ok;
      ok = !stopped && (fill >= span) && !cfg.wild_mask[0];
      for (int k = 0; k < LEN_USE; k++) begin
         idx = IW'(span - SW'(k + 1));
         if ((5'(k) < len) && !cfg.wild_mask[k] && (window[idx] != pattern[8*k +: 8])) begin
            ok = 1'b0;
         end
      end
      for (int j = 0; j < 4; j++) begin
         rel_idx[j] = IW'(a0 - SW'(j));
      end
      result.hit = ok;
      result.rel = {window[rel_idx[3]], window[rel_idx[2]],
                    window[rel_idx[1]], window[rel_idx[0]]};
   end

endmodule

// ===== rtl/wildcard_byte_signature_scan.sv =====
`timescale 1ns / 1ps
// Top level of the wildcard byte signature scanner: config registers, byte window,
// scan state and the result register. Depends on wbss_pkg and wbss_match.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | data_byte, byte_addr, scan_start, region_last
//   rsp     | out       | rsp_valid/rsp_ready  | match_addr, match_number, scan_stopped
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One byte is accepted per cycle while no stall holds the request side.
// The byte enters the window register, the compare stage then feeds the result register.
// A stalled result register holds the compare stage, which then holds the request side.
// Reset is synchronous; it sets the config registers to their defaults and clears the window fill and scan state.
// The csr port is always ready.
module wildcard_byte_signature_scan
   import wbss_pkg::*;
#(
   parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic [63:0]            req_byte_addr,
   input  logic                   req_scan_start,
   input  logic                   req_region_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [63:0]            rsp_match_addr,
   output logic [15:0]            rsp_match_number,
   output logic                   rsp_scan_stopped,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data
);

   localparam int SW      = $clog2(WINDOW_BYTES + 1);
   localparam int DW      = SW + 3;
   localparam int LEN_CAP0 = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;
   localparam int LEN_CAP  = (LEN_CAP0 < WINDOW_BYTES) ? LEN_CAP0 : WINDOW_BYTES;

   cfg_type cfg_ff;

   logic [WINDOW_BYTES-1:0][7:0] window_ff;
   logic [SW-1:0]                region_fill_ff, region_fill_in;
   logic [SW-1:0]                stage_fill_ff, stage_fill_in;
   logic [63:0]                  stage_addr_ff, stage_addr_in;
   logic                         stage_start_ff;
   logic                         stage_valid_ff;
   logic [15:0]                  count_ff, count_in;
   logic                         stopped_ff, stopped_in;

   logic                         rsp_valid_ff;
   logic [63:0]                  rsp_match_addr_ff, rsp_match_addr_in;
   logic [15:0]                  rsp_match_number_ff;
   logic                         rsp_scan_stopped_ff, rsp_scan_stopped_in;

   logic [4:0]    len;
   logic [5:0]    off;
   logic [SW-1:0] span;
   logic [DW-1:0] delta;
   logic          req_fire;
   logic          advance;
   logic          stopped_eff;
   logic [15:0]   count_eff;
   logic [15:0]   count_next;
   logic [15:0]   limit;
   logic [SW-1:0] fill_base;
   match_type     match;

   always_comb begin
      len = cfg_ff.pattern_len;
      if (len == 5'd0) begin
         len = 5'd1;
      end
      if (len > 5'(LEN_CAP)) begin
         len = 5'(LEN_CAP);
      end
      off = {1'b0, cfg_ff.target_offset};
      if (cfg_ff.call_mode && (off > 6'(WINDOW_BYTES - CALL_BYTES))) begin
         off = 6'(WINDOW_BYTES - CALL_BYTES);
      end
      span = SW'(len);
      if (cfg_ff.call_mode && ((SW'(off) + SW'(CALL_BYTES)) > span)) begin
         span = SW'(off) + SW'(CALL_BYTES);
      end
      delta = DW'(off) + DW'(1) - DW'(span);
      if (cfg_ff.call_mode) begin
         delta = delta + DW'(CALL_BYTES);
      end
   end

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      fill_base      = req_scan_start ? '0 : region_fill_ff;
      stage_fill_in  = (fill_base < SW'(WINDOW_BYTES)) ? fill_base + SW'(1) : fill_base;
      region_fill_in = req_region_last ? '0 : stage_fill_in;
      stage_addr_in  = req_byte_addr + {{(64-DW){delta[DW-1]}}, delta};
   end

   wbss_match #(
      .PATTERN_MAX  (PATTERN_MAX),
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_match (
      .window  (window_ff),
      .fill    (stage_fill_ff),
      .span    (span),
      .len     (len),
      .off     (off),
      .cfg     (cfg_ff),
      .stopped (stopped_eff),
      .result  (match)
   );

   always_comb begin
      stopped_eff = stage_start_ff ? 1'b0 : stopped_ff;
      count_eff   = stage_start_ff ? 16'd0 : count_ff;
      count_next  = count_eff + 16'd1;
      limit       = (cfg_ff.max_matches == 16'd0) ? 16'd1 : cfg_ff.max_matches;
      rsp_scan_stopped_in = !cfg_ff.find_all || (count_next >= limit) || (count_next == 16'd0);
      rsp_match_addr_in   = stage_addr_ff;
      if (cfg_ff.call_mode) begin
         rsp_match_addr_in = stage_addr_ff + {{32{match.rel[31]}}, match.rel};
      end
      count_in   = match.hit ? count_next : count_eff;
      stopped_in = match.hit ? rsp_scan_stopped_in : stopped_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {64'd0, 64'd0, 16'd0, 5'd1, 5'd0, 1'b0, 1'b0, 16'd1};
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW: begin
               cfg_ff.pattern_low <= csr_data;
            end
            CSR_PATTERN_HIGH: begin
               cfg_ff.pattern_high <= csr_data;
            end
            CSR_WILD_MASK: begin
               cfg_ff.wild_mask <= csr_data[15:0];
            end
            CSR_PATTERN_LEN: begin
               cfg_ff.pattern_len <= csr_data[4:0];
            end
            CSR_TARGET_OFFSET: begin
               cfg_ff.target_offset <= csr_data[4:0];
            end
            CSR_CALL_MODE: begin
               cfg_ff.call_mode <= csr_data[0];
            end
            CSR_FIND_ALL: begin
               cfg_ff.find_all <= csr_data[0];
            end
            CSR_MAX_MATCHES: begin
               cfg_ff.max_matches <= csr_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         window_ff      <= {window_ff[WINDOW_BYTES-2:0], req_data_byte};
         stage_fill_ff  <= stage_fill_in;
         stage_addr_ff  <= stage_addr_in;
         stage_start_ff <= req_scan_start;
      end
      if (advance && match.hit) begin
         rsp_match_addr_ff   <= rsp_match_addr_in;
         rsp_match_number_ff <= count_eff;
         rsp_scan_stopped_ff <= rsp_scan_stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_fill_ff <= '0;
         stage_valid_ff <= 1'b0;
         count_ff       <= '0;
         stopped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            region_fill_ff <= region_fill_in;
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            count_ff     <= count_in;
            stopped_ff   <= stopped_in;
            rsp_valid_ff <= match.hit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_addr   = rsp_match_addr_ff;
   assign rsp_match_number = rsp_match_number_ff;
   assign rsp_scan_stopped = rsp_scan_stopped_ff;

endmodule

// ===== sim/tb_wildcard_byte_signature_scan.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_signature_scan: random and directed byte
// regions are checked against an in-bench match predictor. Depends on wbss_pkg and the RTL.
module tb_wildcard_byte_signature_scan;
   import wbss_pkg::*;

   localparam int RANDOM_ITEMS  = 1200;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_STALL    = 400;
   localparam int IDLE_LIMIT    = 4000;

   typedef struct {
      logic [7:0]  data;
      logic [63:0] addr;
      logic        first;
      logic        last;
   } mem_byte_t;

   typedef struct {
      logic [63:0] addr;
      logic [15:0] number;
      logic        stopped;
   } scan_match_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic [63:0]            req_byte_addr = '0;
   logic                   req_scan_start = 1'b0;
   logic                   req_region_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [63:0]            rsp_match_addr;
   logic [15:0]            rsp_match_number;
   logic                   rsp_scan_stopped;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   mem_byte_t   byte_queue[$];
   scan_match_t predicted_matches[$];
   int          bytes_pushed = 0;
   int          bytes_accepted = 0;
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          stall_cycles = 0;
   int          long_stall_count = 0;
   bit          long_stall_go = 1'b0;
   bit          long_stall_done = 1'b0;

   cfg_type     cfg;
   logic [7:0]  window_bytes [WINDOW_BYTES_DEF];
   int          region_fill;
   logic [15:0] found_count;
   logic        scan_halted;

   wildcard_byte_signature_scan DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_addr    (req_byte_addr),
      .req_scan_start   (req_scan_start),
      .req_region_last  (req_region_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_addr   (rsp_match_addr),
      .rsp_match_number (rsp_match_number),
      .rsp_scan_stopped (rsp_scan_stopped),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int active_len();
      int n;
      n = cfg.pattern_len;
      if (n == 0) n = 1;
      if (n > PATTERN_BYTES) n = PATTERN_BYTES;
      if (n > PATTERN_MAX_DEF) n = PATTERN_MAX_DEF;
      if (n > WINDOW_BYTES_DEF) n = WINDOW_BYTES_DEF;
      return n;
   endfunction

   task automatic clear_history();
      int i;
      region_fill = 0;
      for (i = 0; i < WINDOW_BYTES_DEF; i++) window_bytes[i] = 8'h00;
   endtask

   task automatic scan_predict(input logic [7:0] data, input logic [63:0] addr,
                               input logic first, input logic last);
      int           i, k, len, off, span, a0;
      logic [127:0] pat;
      logic         hit;
      logic [31:0]  rel;
      logic [63:0]  res;
      logic [15:0]  limit;
      scan_match_t  m;
      pat = {cfg.pattern_high, cfg.pattern_low};
      if (first) begin
         found_count = '0;
         scan_halted = 1'b0;
         clear_history();
      end
      for (i = WINDOW_BYTES_DEF - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
      window_bytes[0] = data;
      if (region_fill < WINDOW_BYTES_DEF) region_fill++;
      len = active_len();
      off = cfg.target_offset;
      if (cfg.call_mode && off > WINDOW_BYTES_DEF - CALL_BYTES)
         off = WINDOW_BYTES_DEF - CALL_BYTES;
      span = len;
      if (cfg.call_mode && off + CALL_BYTES > span) span = off + CALL_BYTES;
      if (!scan_halted && region_fill >= span && !cfg.wild_mask[0]) begin
         hit = 1'b1;
         for (k = 0; k < len; k++) begin
            if (!cfg.wild_mask[k] && window_bytes[span-1-k] != pat[8*k +: 8]) hit = 1'b0;
         end
         if (hit) begin
            res = addr - 64'(span - 1) + 64'(off);
            if (cfg.call_mode) begin
               a0  = span - off - 2;
               rel = {window_bytes[a0-3], window_bytes[a0-2], window_bytes[a0-1],
                      window_bytes[a0]};
               res = res + 64'(CALL_BYTES) + {{32{rel[31]}}, rel};
            end
            limit = (cfg.max_matches == '0) ? 16'd1 : cfg.max_matches;
            m.addr   = res;
            m.number = found_count;
            found_count = found_count + 16'd1;
            scan_halted = !cfg.find_all || found_count >= limit || found_count == '0;
            m.stopped = scan_halted;
            predicted_matches.push_back(m);
         end
      end
      if (last) clear_history();
   endtask

   always @(posedge clock) begin : drive_bytes
      mem_byte_t item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            scan_predict(req_data_byte, req_byte_addr, req_scan_start, req_region_last);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = byte_queue.pop_front();
               req_valid       <= 1'b1;
               req_data_byte   <= item.data;
               req_byte_addr   <= item.addr;
               req_scan_start  <= item.first;
               req_region_last <= item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_matches
      scan_match_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_matches.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected match: addr %h number %0d stopped %b",
                           rsp_match_addr, rsp_match_number, rsp_scan_stopped);
            end else begin
               want = predicted_matches.pop_front();
               if (want.addr !== rsp_match_addr || want.number !== rsp_match_number ||
                   want.stopped !== rsp_scan_stopped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("match differs: expected addr %h number %0d stopped %b, got addr %h number %0d stopped %b",
                              want.addr, want.number, want.stopped,
                              rsp_match_addr, rsp_match_number, rsp_scan_stopped);
               end
            end
         end
         if (long_stall_go && !long_stall_done) begin
            rsp_ready <= 1'b0;
            if (long_stall_count == LONG_STALL) long_stall_done = 1'b1;
            else long_stall_count++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == IDLE_LIMIT) begin
         $display("wildcard_byte_signature_scan: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN_LOW:   cfg.pattern_low   = val;
         CSR_PATTERN_HIGH:  cfg.pattern_high  = val;
         CSR_WILD_MASK:     cfg.wild_mask     = val[15:0];
         CSR_PATTERN_LEN:   cfg.pattern_len   = val[4:0];
         CSR_TARGET_OFFSET: cfg.target_offset = val[4:0];
         CSR_CALL_MODE:     cfg.call_mode     = val[0];
         CSR_FIND_ALL:      cfg.find_all      = val[0];
         CSR_MAX_MATCHES:   cfg.max_matches   = val[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_cfg(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] wm, input logic [4:0] len,
                            input logic [4:0] off, input logic cm, input logic fa,
                            input logic [15:0] mm);
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_WILD_MASK, 64'(wm));
      write_reg(CSR_PATTERN_LEN, 64'(len));
      write_reg(CSR_TARGET_OFFSET, 64'(off));
      write_reg(CSR_CALL_MODE, 64'(cm));
      write_reg(CSR_FIND_ALL, 64'(fa));
      write_reg(CSR_MAX_MATCHES, 64'(mm));
      csr_valid <= 1'b0;
   endtask

   task automatic random_cfg();
      logic [63:0] lo, hi;
      logic [15:0] wm, mm;
      logic [4:0]  len, off;
      logic        cm, fa;
      int          r, k;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if ($urandom_range(9) == 0) lo = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(9) == 0) hi = $urandom_range(1) ? '1 : '0;
      r = $urandom_range(19);
      if (r == 0) len = 5'd0;
      else if (r == 1) len = 5'($urandom_range(17, 31));
      else if (r <= 5) len = 5'($urandom_range(7, 16));
      else len = 5'($urandom_range(1, 6));
      wm = '0;
      for (k = 1; k < 16; k++) wm[k] = ($urandom_range(4) == 0);
      wm[0] = ($urandom_range(19) == 0);
      cm = ($urandom_range(9) < 4);
      r = $urandom_range(9);
      if (r == 0) off = 5'($urandom_range(28, 31));
      else if (r <= 2) off = 5'($urandom_range(7, 27));
      else off = 5'($urandom_range(0, 6));
      fa = ($urandom_range(9) < 7);
      r = $urandom_range(9);
      if (r == 0) mm = 16'd0;
      else if (r == 1) mm = 16'hFFFF;
      else mm = 16'($urandom_range(1, 8));
      apply_cfg(lo, hi, wm, len, off, cm, fa, mm);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic [63:0] addr,
                             input logic first, input logic last);
      mem_byte_t item;
      item.data  = data;
      item.addr  = addr;
      item.first = first;
      item.last  = last;
      byte_queue.push_back(item);
      bytes_pushed++;
   endtask

   // Regions are seeded with pattern bytes and whole pattern copies so that
   // matches, overlaps and stops occur often; a few stray start and end flags
   // break the regions up.
   task automatic queue_region(input int nbytes, input logic first, input int plant_pct);
      logic [7:0]   region_data[];
      logic [127:0] pat;
      logic [63:0]  base;
      logic         s, e;
      int           i, k, len;
      pat = {cfg.pattern_high, cfg.pattern_low};
      len = active_len();
      region_data = new[nbytes];
      for (i = 0; i < nbytes; i++) begin
         if ($urandom_range(1) == 0) region_data[i] = 8'($urandom);
         else region_data[i] = pat[8*$urandom_range(len - 1) +: 8];
      end
      for (i = 0; i + len <= nbytes; i++) begin
         if ($urandom_range(99) < plant_pct) begin
            for (k = 0; k < len; k++)
               if (!cfg.wild_mask[k]) region_data[i+k] = pat[8*k +: 8];
         end
      end
      if ($urandom_range(6) == 0) base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40));
      else base = {$urandom, $urandom};
      for (i = 0; i < nbytes; i++) begin
         s = (first && i == 0) || ($urandom_range(99) < 2);
         e = (i == nbytes - 1) || ($urandom_range(99) < 2);
         queue_byte(region_data[i], base + 64'(i), s, e);
      end
   endtask

   task automatic wait_idle();
      while (bytes_accepted != bytes_pushed || predicted_matches.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int random_items;
      int phase_bytes;
      int n, i;
      logic first;
      cfg = '0;
      cfg.pattern_len = 5'd1;
      cfg.max_matches = 16'd1;
      found_count = '0;
      scan_halted = 1'b0;
      clear_history();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 48;

      // Reset settings: first-only mode stops the scan, a new scan restarts it.
      queue_byte(8'h00, 64'h0, 1'b1, 1'b0);
      queue_byte(8'h00, 64'h1, 1'b0, 1'b0);
      queue_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      wait_idle();

      // Zero length and zero limit.
      apply_cfg(64'hFF, 64'h0, 16'h0000, 5'd0, 5'd0, 1'b0, 1'b1, 16'd0);
      queue_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      queue_byte(8'hFF, 64'h10, 1'b0, 1'b1);
      wait_idle();

      // Leading wildcard never matches.
      apply_cfg(64'hFFFF, 64'h0, 16'h0001, 5'd2, 5'd0, 1'b0, 1'b1, 16'hFFFF);
      queue_byte(8'hFF, 64'h20, 1'b1, 1'b0);
      queue_byte(8'hFF, 64'h21, 1'b0, 1'b1);
      wait_idle();

      // Call decode, then a region too short to hold the call field.
      apply_cfg(64'hE8, 64'h0, 16'h0000, 5'd1, 5'd0, 1'b1, 1'b1, 16'hFFFF);
      queue_byte(8'hE8, 64'h1000, 1'b1, 1'b0);
      queue_byte(8'hFB, 64'h1001, 1'b0, 1'b0);
      queue_byte(8'hFF, 64'h1002, 1'b0, 1'b0);
      queue_byte(8'hFF, 64'h1003, 1'b0, 1'b0);
      queue_byte(8'hFF, 64'h1004, 1'b0, 1'b1);
      queue_byte(8'hE8, 64'h2000, 1'b0, 1'b0);
      queue_byte(8'h01, 64'h2001, 1'b0, 1'b0);
      queue_byte(8'h02, 64'h2002, 1'b0, 1'b0);
      queue_byte(8'hE8, 64'h2003, 1'b0, 1'b1);
      wait_idle();

      // Overlapping matches up to the limit, a plain offset of 27, address wrap.
      apply_cfg({8{8'hAA}}, 64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 5'd2, 5'd27,
                1'b0, 1'b1, 16'd2);
      for (i = 0; i < 4; i++)
         queue_byte(8'hAA, 64'hFFFF_FFFF_FFFF_FFFE + 64'(i), i == 0, i == 3);
      wait_idle();

      // Receiver holds off while most requests match, so the block backs up.
      apply_cfg(64'h5A, 64'h0, 16'h0000, 5'd1, 5'd3, 1'b0, 1'b1, 16'hFFFF);
      long_stall_go = 1'b1;
      random_items = 0;
      for (n = 0; n < 5; n++) begin
         queue_region(30, n == 0, 90);
         random_items += 30;
      end
      wait_idle();

      while (random_items < RANDOM_ITEMS) begin
         if (random_items < RANDOM_ITEMS / 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 48;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_cfg();
         first = 1'b1;
         phase_bytes = 0;
         while (phase_bytes < 80) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(33, 48) : $urandom_range(1, 24);
            queue_region(n, first || ($urandom_range(3) == 0), 8);
            first = 1'b0;
            phase_bytes += n;
         end
         random_items += phase_bytes;
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && predicted_matches.size() == 0) begin
         $display("wildcard_byte_signature_scan: match");
      end else begin
         $display("wildcard_byte_signature_scan: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/wbss_pkg.sv
rtl/wbss_match.sv
rtl/wildcard_byte_signature_scan.sv
sim/tb_wildcard_byte_signature_scan.sv
